// File: hdl/halving_ring_allreduce_schedule_top_assert.svh
// Assertion macros for the schedule block's controller (hrar_ctrl).
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef HALVING_RING_ALLREDUCE_SCHEDULE_TOP_ASSERT_SVH
`define HALVING_RING_ALLREDUCE_SCHEDULE_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define HRAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define HRAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/hrar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hrar_pkg;

  // Largest rank count the block is built for.
  localparam int MAX_RANKS = 128;
  // Largest rank count the 7-bit index fields can carry.
  localparam int FIELD_LIMIT = 128;
  localparam int RANK_LIMIT = (MAX_RANKS < FIELD_LIMIT) ? MAX_RANKS : FIELD_LIMIT;

  // Configuration register indexes.
  localparam logic CFG_RANK_COUNT = 1'b0;
  localparam logic CFG_OWN_INDEX  = 1'b1;

  // Phase codes.
  localparam logic CMD_REDUCE_SCATTER = 1'b0;
  localparam logic CMD_ALL_GATHER     = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [2:0] step_number;
  } in_word_t;

  typedef struct packed {
    logic [6:0] send_peer;
    logic [6:0] recv_peer;
    logic [6:0] slice_total;
    logic [5:0] pair_number;
    logic [6:0] tx_slice;
    logic [6:0] rx_slice;
    logic       last_pair;
    logic       bad_request;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic calc;
    logic advance;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } dp_status_t;

  // Smallest k with 2^k >= n; the comparisons are independent of each other.
  function automatic logic [3:0] step_count(input logic [7:0] n);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if ((9'd1 << i) < {1'b0, n}) begin
        k = 4'(i + 1);
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// File: hdl/hrar_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module hrar_dp (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire                   cfg_index,
  input  wire [7:0]             cfg_wdata,
  input  hrar_pkg::in_word_t    in_data,
  input  hrar_pkg::ctl_cmd_t    ctl,
  output hrar_pkg::dp_status_t  status,
  output hrar_pkg::out_word_t   out_data
);
  import hrar_pkg::*;

  logic [7:0] rank_count_r;
  logic [6:0] own_index_r;
  logic       cmd_r;
  logic [2:0] step_r;
  logic [6:0] to_r, from_r, tx_r, rx_r, total_r;
  logic [7:0] stride_r;
  logic [5:0] pair_r;
  logic       bad_r;

  logic [3:0] nsteps;
  logic       req_bad;
  logic [2:0] shift_k;
  logic [8:0] n9, r9, d9, dbl9, sum9, minus9, plus9, stride9, pairs9;

  // Subtract the stride modulo n; x and stride are both below n.
  function automatic logic [6:0] wrap_sub(input logic [6:0] x, input logic [7:0] stride,
                                          input logic [7:0] n);
    logic [8:0] xe;
    logic [8:0] res;
    xe = {2'b00, x};
    if (xe >= {1'b0, stride}) begin
      res = xe - {1'b0, stride};
    end else begin
      res = xe + {1'b0, n} - {1'b0, stride};
    end
    return res[6:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_count_r <= 8'd1;
      own_index_r  <= 7'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RANK_COUNT) begin
        rank_count_r <= cfg_wdata;
      end else begin
        own_index_r <= cfg_wdata[6:0];
      end
    end
  end

  // Step setup: distance, peers, stride and pair count.
  always_comb begin
    nsteps  = step_count(rank_count_r);
    req_bad = (rank_count_r == 8'd0) || (rank_count_r > 8'(RANK_LIMIT)) ||
              ({1'b0, own_index_r} >= rank_count_r) || ({1'b0, step_r} >= nsteps);
    if (cmd_r == CMD_ALL_GATHER) begin
      shift_k = 3'(nsteps - 4'd1 - {1'b0, step_r});
    end else begin
      shift_k = step_r;
    end
    n9   = {1'b0, rank_count_r};
    r9   = {2'b00, own_index_r};
    d9   = 9'd1 << shift_k;
    dbl9 = d9 << 1;
    sum9 = r9 + d9;
    if (r9 >= d9) begin
      minus9 = r9 - d9;
    end else begin
      minus9 = r9 + n9 - d9;
    end
    if (sum9 >= n9) begin
      plus9 = sum9 - n9;
    end else begin
      plus9 = sum9;
    end
    if (dbl9 >= n9) begin
      stride9 = dbl9 - n9;
    end else begin
      stride9 = dbl9;
    end
    pairs9 = (n9 - 9'd1 + d9) >> ({1'b0, shift_k} + 4'd1);
  end

  // Request latch, setup load and per-pair stepping.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_data.cmd;
      step_r <= in_data.step_number;
    end
    if (ctl.calc) begin
      bad_r    <= req_bad;
      pair_r   <= 6'd0;
      total_r  <= pairs9[6:0];
      stride_r <= stride9[7:0];
      if (cmd_r == CMD_ALL_GATHER) begin
        to_r   <= plus9[6:0];
        from_r <= minus9[6:0];
        tx_r   <= own_index_r;
        rx_r   <= minus9[6:0];
      end else begin
        to_r   <= minus9[6:0];
        from_r <= plus9[6:0];
        tx_r   <= minus9[6:0];
        rx_r   <= own_index_r;
      end
    end else if (ctl.advance) begin
      pair_r <= pair_r + 6'd1;
      tx_r   <= wrap_sub(tx_r, stride_r, rank_count_r);
      rx_r   <= wrap_sub(rx_r, stride_r, rank_count_r);
    end
  end

  // The current pair is the last one of the step, or the error word.
  assign status.last = bad_r || ({1'b0, pair_r} + 7'd1 == total_r);

  // Output word; an error word carries only the error flag.
  always_comb begin
    out_data = '0;
    if (bad_r) begin
      out_data.bad_request = 1'b1;
    end else begin
      out_data.send_peer   = to_r;
      out_data.recv_peer   = from_r;
      out_data.slice_total = total_r;
      out_data.pair_number = pair_r;
      out_data.tx_slice    = tx_r;
      out_data.rx_slice    = rx_r;
      out_data.last_pair   = status.last;
    end
  end

endmodule
`default_nettype wire

// File: hdl/hrar_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "halving_ring_allreduce_schedule_top_assert.svh"
module hrar_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  hrar_pkg::dp_status_t  status,
  output hrar_pkg::ctl_cmd_t    ctl
);
  import hrar_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready && status.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Handshakes and datapath commands.
  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_EMIT);
  assign ctl.load    = in_ready && in_valid;
  assign ctl.calc    = (state_r == S_CALC);
  assign ctl.advance = out_valid && out_ready && !status.last;

  `HRAR_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken while a word is pending")
  `HRAR_ASSERT_NEXT(a_setup_after_take, in_valid && in_ready, ctl.calc && !out_valid,
                    "no setup cycle after an accepted request")
  `HRAR_ASSERT_NEXT(a_more_pairs, out_valid && out_ready && !status.last, out_valid,
                    "pair stream stopped before its last word")
  `HRAR_ASSERT_NEXT(a_done_after_last, out_valid && out_ready && status.last, in_ready,
                    "not ready for a request after the last word")

endmodule
`default_nettype wire

// File: hdl/halving_ring_allreduce_schedule_top.sv
// Halving/doubling all-reduce schedule step generator for one rank.
// Configuration: write rank_count (index 0) and own_index (index 1) through
// cfg_we/cfg_index/cfg_wdata while the block is idle; writes take effect at once.
// Input channel (in_valid/in_ready/in_data): one word names the phase and the step.
// Result channel (out_valid/out_ready/out_data): one word per slice pair of the
// step, pair_number counting up and last_pair set on the final word. A bad step,
// index or rank count gives a single word with only bad_request set.
// Timing: after a request is taken, a setup state computes distance, peers and
// stride; then one word is offered per cycle while out_ready is high, paced by
// the one-pair-per-cycle slice stepper.
// Stall: a word stays on out_data until out_ready; the stepper holds meanwhile.
// A new request is taken only after the last word of the previous one.
// Reset (rst_n low at a clock edge): rank_count returns to 1, own_index to 0 and
// the controller to idle; no word is pending.
`timescale 1ns / 1ps
`default_nettype none
module halving_ring_allreduce_schedule_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire                  cfg_index,
  input  wire [7:0]            cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  hrar_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output hrar_pkg::out_word_t  out_data
);
  import hrar_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t status;

  // Sequencer.
  hrar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .ctl       (ctl)
  );

  // Configuration, step setup and slice stepping.
  hrar_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .ctl       (ctl),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
